[hw/rtl/prt_pkg.sv]
// shared types and constants for the per-source replay filter
`default_nettype none
package prt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [31:0] STALE_MS_RESET = 32'd900000;

  typedef enum logic [2:0] {
    OC_UPDATE       = 3'd0,
    OC_REBOOT       = 3'd1,
    OC_REPLAY_DROP  = 3'd2,
    OC_FREE_INSERT  = 3'd3,
    OC_STALE_EVICT  = 3'd4,
    OC_OLDEST_EVICT = 3'd5,
    OC_FULL_DROP    = 3'd6
  } outcome_t;

  typedef struct packed {
    logic [7:0]  source_address;
    logic [31:0] peer_nonce;
    logic [31:0] msg_counter;
    logic [31:0] now_ms;
    logic        trusted;
  } in_t;

  typedef struct packed {
    logic        accept;
    logic [2:0]  outcome;
    logic [6:0]  peak_used;
    logic [31:0] eviction_count;
    logic [31:0] stale_eviction_count;
    logic [31:0] full_drop_count;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  source;
    logic [31:0] nonce;
    logic [31:0] counter;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic             match_f;
    logic [IDX_W-1:0] match_idx;
    logic [31:0]      match_nonce;
    logic [31:0]      match_counter;
    logic             empty_f;
    logic [IDX_W-1:0] empty_idx;
    logic             oldest_f;
    logic [IDX_W-1:0] oldest_idx;
    logic [31:0]      oldest_time;
    logic             stale_f;
    logic [IDX_W-1:0] stale_idx;
    logic [31:0]      stale_time;
  } scan_t;

endpackage
`default_nettype wire

[hw/rtl/prt_cell.sv]
// one table slot of the rotating entry ring
`default_nettype none
module prt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  logic            wr,
  input  prt_pkg::entry_t prev,
  input  prt_pkg::entry_t wr_data,
  output prt_pkg::entry_t q
);
  import prt_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (wr) begin
      q_r <= wr_data;
    end else if (shift) begin
      q_r <= prev;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

[hw/rtl/prt_scan.sv]
// accumulates match, free, oldest and stale picks as entries pass the ring head
`default_nettype none
module prt_scan (
  input  logic                      clk,
  input  logic                      clear,
  input  logic                      step,
  input  logic [prt_pkg::IDX_W-1:0] idx,
  input  prt_pkg::entry_t           head,
  input  prt_pkg::in_t              item,
  input  logic [31:0]               stale_ms,
  output prt_pkg::scan_t            res
);
  import prt_pkg::*;

  scan_t res_r, res_nxt;
  logic [31:0] age;
  logic [31:0] d_old;
  logic [31:0] d_stale;

  assign age     = item.now_ms - head.seen;
  assign d_old   = head.seen - res_r.oldest_time;
  assign d_stale = head.seen - res_r.stale_time;

  always_comb begin
    res_nxt = res_r;
    if (clear) begin
      res_nxt = '0;
    end else if (step && !res_r.match_f) begin
      if (!head.valid) begin
        if (!res_r.empty_f) begin
          res_nxt.empty_f   = 1'b1;
          res_nxt.empty_idx = idx;
        end
      end else begin
        res_nxt.used = res_r.used + CNT_W'(1);
        if (head.source == item.source_address) begin
          res_nxt.match_f       = 1'b1;
          res_nxt.match_idx     = idx;
          res_nxt.match_nonce   = head.nonce;
          res_nxt.match_counter = head.counter;
        end else begin
          if (!res_r.oldest_f || d_old[31]) begin
            res_nxt.oldest_f    = 1'b1;
            res_nxt.oldest_idx  = idx;
            res_nxt.oldest_time = head.seen;
          end
          if (age >= stale_ms && (!res_r.stale_f || d_stale[31])) begin
            res_nxt.stale_f    = 1'b1;
            res_nxt.stale_idx  = idx;
            res_nxt.stale_time = head.seen;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

[hw/rtl/per_source_replay_filter.sv]
// top level of the per-source replay filter
// Each transaction runs from start to the result strobe in three steps: the
// item is captured, the entry ring rotates every slot past the scan logic in
// turn, and the chosen slot is decided and written. busy stays high until the
// decision cycle is done; the result strobe appears in the cycle after it and
// cannot be held. The stale_ms register takes a write only while the block is
// idle; cfg_ready is low while busy is high.
`default_nettype none
module per_source_replay_filter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  prt_pkg::in_t  in_item,
  output logic          out_valid,
  output prt_pkg::out_t out_result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import prt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  in_t              item_r;
  logic [31:0]      stale_ms_r;
  logic [6:0]       peak_r, peak_nxt;
  logic [31:0]      evict_r, evict_nxt;
  logic [31:0]      evict_stale_r, evict_stale_nxt;
  logic [31:0]      drop_full_r, drop_full_nxt;
  logic             out_valid_r;
  out_t             out_r, out_nxt;

  entry_t           cell_q [TABLE_ENTRIES];
  entry_t           wr_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  scan_t            scan;
  logic             accept_item;
  logic [CNT_W-1:0] used_fin;
  logic             free_ins;

  assign accept_item = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign cfg_ready   = (state_r == ST_IDLE);

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    prt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (state_r == ST_SCAN),
      .wr      (wr_en && (wr_idx == IDX_W'(k))),
      .prev    (cell_q[(k + 1) % TABLE_ENTRIES]),
      .wr_data (wr_data),
      .q       (cell_q[k])
    );
  end

  prt_scan u_scan (
    .clk      (clk),
    .clear    (accept_item),
    .step     (state_r == ST_SCAN),
    .idx      (cnt_r),
    .head     (cell_q[0]),
    .item     (item_r),
    .stale_ms (stale_ms_r),
    .res      (scan)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    peak_nxt        = peak_r;
    evict_nxt       = evict_r;
    evict_stale_nxt = evict_stale_r;
    drop_full_nxt   = drop_full_r;
    out_nxt         = out_r;
    wr_en           = 1'b0;
    wr_idx          = scan.match_idx;
    free_ins        = 1'b0;
    wr_data.valid   = 1'b1;
    wr_data.source  = item_r.source_address;
    wr_data.nonce   = item_r.peer_nonce;
    wr_data.counter = item_r.msg_counter;
    wr_data.seen    = item_r.now_ms;
    out_nxt.accept  = 1'b0;
    out_nxt.outcome = OC_UPDATE;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
        if (scan.match_f) begin
          if (scan.match_nonce == item_r.peer_nonce &&
              item_r.msg_counter <= scan.match_counter) begin
            out_nxt.outcome = OC_REPLAY_DROP;
          end else begin
            out_nxt.accept  = 1'b1;
            out_nxt.outcome = (scan.match_nonce != item_r.peer_nonce &&
                               scan.match_nonce != 32'd0) ? OC_REBOOT : OC_UPDATE;
            wr_en = 1'b1;
          end
        end else if (scan.empty_f) begin
          free_ins        = 1'b1;
          out_nxt.accept  = 1'b1;
          out_nxt.outcome = OC_FREE_INSERT;
          wr_en           = 1'b1;
          wr_idx          = scan.empty_idx;
        end else if (scan.stale_f) begin
          out_nxt.accept  = 1'b1;
          out_nxt.outcome = OC_STALE_EVICT;
          wr_en           = 1'b1;
          wr_idx          = scan.stale_idx;
          evict_nxt       = evict_r + 32'd1;
          evict_stale_nxt = evict_stale_r + 32'd1;
        end else if (item_r.trusted && scan.oldest_f) begin
          out_nxt.accept  = 1'b1;
          out_nxt.outcome = OC_OLDEST_EVICT;
          wr_en           = 1'b1;
          wr_idx          = scan.oldest_idx;
          evict_nxt       = evict_r + 32'd1;
        end else begin
          out_nxt.outcome = OC_FULL_DROP;
          drop_full_nxt   = drop_full_r + 32'd1;
        end
        if (7'(used_fin) > peak_r) begin
          peak_nxt = 7'(used_fin);
        end
        out_nxt.peak_used            = peak_nxt;
        out_nxt.eviction_count       = evict_nxt;
        out_nxt.stale_eviction_count = evict_stale_nxt;
        out_nxt.full_drop_count      = drop_full_nxt;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign used_fin = scan.used + CNT_W'(free_ins);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      stale_ms_r    <= STALE_MS_RESET;
      peak_r        <= '0;
      evict_r       <= '0;
      evict_stale_r <= '0;
      drop_full_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      peak_r        <= peak_nxt;
      evict_r       <= evict_nxt;
      evict_stale_r <= evict_stale_nxt;
      drop_full_r   <= drop_full_nxt;
      out_valid_r   <= (state_r == ST_UPD);
      if (cfg_valid && cfg_ready) begin
        stale_ms_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_item) begin
      item_r <= in_item;
    end
    if (state_r == ST_UPD) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule
`default_nettype wire
